@@ hdl/lvc_pkg.sv @@
package lvc_pkg;

	localparam int ENTRIES_DEF  = 8;
	localparam int TAG_BITS_DEF = 32;
	localparam int SET_BITS_DEF = 10;

	typedef enum logic [1:0] {
		OUT_MISS_CLEAN = 2'd0,
		OUT_MISS_DIRTY = 2'd1,
		OUT_HIT_CLEAN  = 2'd2,
		OUT_HIT_DIRTY  = 2'd3
	} outcome_t;

endpackage

@@ hdl/lvc_cell.sv @@
module lvc_cell #(
	parameter int TAG_BITS = lvc_pkg::TAG_BITS_DEF,
	parameter int SET_BITS = lvc_pkg::SET_BITS_DEF,
	localparam int ENT_W = TAG_BITS + SET_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic [TAG_BITS-1:0] lookup_tag,
	input  logic [SET_BITS-1:0] lookup_set,
	input  logic [ENT_W-1:0] prev_ent,
	input  logic             found_in,
	input  logic [ENT_W-1:0] vic_in,
	output logic [ENT_W-1:0] cur_ent,
	output logic             found_out,
	output logic [ENT_W-1:0] vic_out
);

	// entry layout: {valid, dirty, set, tag}
	logic [ENT_W-1:0] ent_q;
	logic             match;

	assign match = ent_q[ENT_W-1]
		&& (ent_q[TAG_BITS-1:0] == lookup_tag)
		&& (ent_q[TAG_BITS +: SET_BITS] == lookup_set);

	assign found_out = found_in | match;
	assign vic_out   = (match && !found_in) ? ent_q : vic_in;
	assign cur_ent   = ent_q;

	// cells up to and including the chosen one move one place toward lru
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (upd && !found_in) begin
			ent_q <= prev_ent;
		end
	end

endmodule

@@ hdl/lru_victim_cache.sv @@
// channel | signals                                        | role
// in      | in_valid, in_ready, lookup_*, fill_*           | request word
// out     | out_valid, out_ready, outcome, writeback_*     | result word
//
// one request per cycle while in_ready is high; its result word appears in the
// output register on the next cycle (a single compare-and-shift pass through
// the cell row, cell 0 most recent, last cell least recent)
// after reset all entries are invalid; no clearing pass is needed
// a stalled result word holds; a new request is taken while the output
// register is empty or out_ready is high, so in_ready drops only while a
// result word waits with out_ready low
module lru_victim_cache #(
	parameter int ENTRIES  = lvc_pkg::ENTRIES_DEF,
	parameter int TAG_BITS = lvc_pkg::TAG_BITS_DEF,
	parameter int SET_BITS = lvc_pkg::SET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TAG_BITS-1:0] lookup_tag,
	input  logic [SET_BITS-1:0] lookup_set,
	input  logic [TAG_BITS-1:0] fill_tag,
	input  logic [SET_BITS-1:0] fill_set,
	input  logic                fill_dirty,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          outcome,
	output logic                writeback_valid,
	output logic [TAG_BITS-1:0] writeback_tag,
	output logic [SET_BITS-1:0] writeback_set
);

	localparam int ENT_W = TAG_BITS + SET_BITS + 2;

	logic                upd;
	logic [ENT_W-1:0]    fill_ent;
	logic [ENT_W-1:0]    cur_ent [ENTRIES];
	logic [ENT_W-1:0]    vic     [ENTRIES+1];
	logic                found   [ENTRIES+1];
	logic                hit;
	logic [ENT_W-1:0]    victim;
	logic                wb;
	lvc_pkg::outcome_t   outcome_d;

	logic                out_valid_q;
	logic [1:0]          outcome_q;
	logic                wb_valid_q;
	logic [TAG_BITS-1:0] wb_tag_q;
	logic [SET_BITS-1:0] wb_set_q;

	assign in_ready = !out_valid_q || out_ready;
	assign upd      = in_valid && in_ready;
	assign fill_ent = {1'b1, fill_dirty, fill_set, fill_tag};

	assign found[0] = 1'b0;
	assign vic[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lvc_cell #(
			.TAG_BITS(TAG_BITS),
			.SET_BITS(SET_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (upd),
			.lookup_tag(lookup_tag),
			.lookup_set(lookup_set),
			.prev_ent  ((i == 0) ? fill_ent : cur_ent[(i == 0) ? 0 : i-1]),
			.found_in  (found[i]),
			.vic_in    (vic[i]),
			.cur_ent   (cur_ent[i]),
			.found_out (found[i+1]),
			.vic_out   (vic[i+1])
		);
	end

	// on a miss the least recent cell is displaced
	assign hit    = found[ENTRIES];
	assign victim = hit ? vic[ENTRIES] : cur_ent[ENTRIES-1];
	assign wb     = victim[ENT_W-1] & victim[ENT_W-2];

	always_comb begin
		unique case ({hit, wb})
			2'b00:   outcome_d = lvc_pkg::OUT_MISS_CLEAN;
			2'b01:   outcome_d = lvc_pkg::OUT_MISS_DIRTY;
			2'b10:   outcome_d = lvc_pkg::OUT_HIT_CLEAN;
			default: outcome_d = lvc_pkg::OUT_HIT_DIRTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			outcome_q  <= outcome_d;
			wb_valid_q <= wb;
			wb_tag_q   <= wb ? victim[TAG_BITS-1:0] : '0;
			wb_set_q   <= wb ? victim[TAG_BITS +: SET_BITS] : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign outcome         = outcome_q;
	assign writeback_valid = wb_valid_q;
	assign writeback_tag   = wb_tag_q;
	assign writeback_set   = wb_set_q;

endmodule

@@ hdl/lvc_checker.sv @@
module lvc_checker #(
	parameter int TAG_BITS = lvc_pkg::TAG_BITS_DEF,
	parameter int SET_BITS = lvc_pkg::SET_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          outcome,
	input logic                writeback_valid,
	input logic [TAG_BITS-1:0] writeback_tag,
	input logic [SET_BITS-1:0] writeback_set
);

	// dirty displaced codes and writeback flag agree
	a_wb_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (writeback_valid == outcome[0]))
		else $error("writeback flag disagrees with outcome");

	// no dirty victim means zeroed writeback fields
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !writeback_valid) |-> (writeback_tag == '0 && writeback_set == '0))
		else $error("writeback fields not zero");

	// every accepted request yields a result word next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted request gave no result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(outcome)
			&& $stable(writeback_tag) && $stable(writeback_set)))
		else $error("stalled result changed");

endmodule

bind lru_victim_cache lvc_checker #(
	.TAG_BITS(TAG_BITS),
	.SET_BITS(SET_BITS)
) u_lvc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.outcome        (outcome),
	.writeback_valid(writeback_valid),
	.writeback_tag  (writeback_tag),
	.writeback_set  (writeback_set)
);
